@@ rtl/sida_pkg.sv @@
// Shared types and constants for the signed integer to decimal text converter.
package sida_pkg;

   localparam int BIN_WIDTH       = 32;
   localparam int NUM_DIGITS      = 10;
   localparam int BCD_WIDTH       = 4 * NUM_DIGITS;
   localparam int DIGIT_IDX_WIDTH = 4;
   localparam int STEP_WIDTH      = 5;
   localparam int CHAR_WIDTH      = 6;

   typedef logic [CHAR_WIDTH-1:0]      char_type;
   typedef logic [DIGIT_IDX_WIDTH-1:0] digit_idx_type;

   localparam char_type CODE_ZERO  = 6'd48;
   localparam char_type CODE_MINUS = 6'd45;

   typedef struct packed {
      logic                 neg;
      logic [BIN_WIDTH-1:0] mag;
   } item_type;

endpackage

@@ rtl/sida_front.sv @@
// Front end: accept a value, split it into sign and unsigned magnitude.
module sida_front (
   input  logic                 start,
   input  logic [31:0]          req_value,
   input  logic                 queue_full,
   output logic                 busy,
   output logic                 push,
   output sida_pkg::item_type   push_item
);
   import sida_pkg::*;

   logic neg;

   assign neg  = req_value[BIN_WIDTH-1];
   assign busy = queue_full;
   assign push = start & ~queue_full;

   // the most negative value negates onto itself, which is its correct magnitude
   assign push_item.neg = neg;
   assign push_item.mag = neg ? (BIN_WIDTH'(0) - req_value) : req_value;

endmodule

@@ rtl/sida_queue.sv @@
// Short first-in first-out queue of classified items between front and back.
module sida_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sida_pkg::item_type   push_item,
   input  logic                 pop,
   output sida_pkg::item_type   pop_item,
   output logic                 full,
   output logic                 empty
);
   import sida_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type          store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

endmodule

@@ rtl/sida_back.sv @@
// Back end: shift-and-add-3 conversion, then character emission.
module sida_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sida_pkg::item_type   pop_item,
   input  logic                 queue_empty,
   output logic                 pop,
   output logic                 rsp_strobe,
   output sida_pkg::char_type   rsp_char_code,
   output logic                 rsp_last_char
);
   import sida_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CONV  = 3'd1;
   localparam logic [2:0] ST_FIND  = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_DIGIT = 3'd4;

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(BIN_WIDTH - 1);

   logic [2:0]            state_ff, state_in;
   logic                  neg_ff, neg_in;
   logic [BIN_WIDTH-1:0]  bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]  bcd_ff, bcd_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   digit_idx_type         idx_ff, idx_in;
   logic                  strobe_ff, strobe_in;
   char_type              char_ff, char_in;
   logic                  last_ff, last_in;

   logic [3:0]            digit [NUM_DIGITS];
   logic [BCD_WIDTH-1:0]  bcd_adj;
   digit_idx_type         lead_idx;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digit[i] = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (digit[i] >= 4'd5) ? digit[i] + 4'd3 : digit[i];
      end
   end

   // most significant non-zero digit; zero keeps the units digit
   always_comb begin
      lead_idx = '0;
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (digit[i] != 4'd0) begin
            lead_idx = DIGIT_IDX_WIDTH'(i);
         end
      end
   end

   assign pop = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      state_in  = state_ff;
      neg_in    = neg_ff;
      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               neg_in   = pop_item.neg;
               bin_in   = pop_item.mag;
               bcd_in   = '0;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in  = {bcd_adj[BCD_WIDTH-2:0], bin_ff[BIN_WIDTH-1]};
            bin_in  = {bin_ff[BIN_WIDTH-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = lead_idx;
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CODE_MINUS;
            last_in   = 1'b0;
            state_in  = ST_DIGIT;
         end
         ST_DIGIT: begin
            strobe_in = 1'b1;
            char_in   = CODE_ZERO + {2'b00, digit[idx_ff]};
            last_in   = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      step_ff <= step_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_SIGN) || ($past(state_ff) == ST_DIGIT))
      else $error("character emitted outside the emit states");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_char |-> state_ff == ST_IDLE)
      else $error("final character did not return the converter to idle");

   a_find_after_conv: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIND |-> $past(state_ff) == ST_CONV && $past(step_ff) == LAST_STEP)
      else $error("digit search entered before all shift steps");

   a_lead_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGIT |-> idx_ff < DIGIT_IDX_WIDTH'(NUM_DIGITS))
      else $error("digit index out of range");

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// The first character of a value comes out after the queue, the shift-and-add-3 loop and the digit search.
// Each value holds the converter for the 32-step shift-and-add-3 loop of the back end and then
//   for its n = 1..11 characters; the back end takes a new value from the queue only when idle.
// A two-entry queue lets up to two further values be accepted while one converts.
// Results go out one per cycle on a strobe; the receiver cannot stall them.
// Reset (synchronous) empties the queue, idles the converter and drops any pending result.
module signed_int_to_decimal_ascii #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [31:0]          req_value,
   output logic                 rsp_strobe,
   output logic [5:0]           rsp_char_code,
   output logic                 rsp_last_char
);
   import sida_pkg::*;

   // front to queue
   logic      push;
   item_type  push_item;
   logic      queue_full;

   // queue to back
   logic      pop;
   item_type  pop_item;
   logic      queue_empty;

   // accept a transaction and classify it into sign and magnitude
   sida_front u_front (
      .start      (start),
      .req_value  (req_value),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (push),
      .push_item  (push_item)
   );

   // hold classified values until the converter is free
   sida_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // convert to decimal digits, then emit sign and digits one per cycle
   sida_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_item      (pop_item),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

@@ dv/sida_text_checker.sv @@
// Checker for the decimal text converter: predicts each value's characters and compares them.
module sida_text_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [31:0] req_value,
   input  logic        rsp_strobe,
   input  logic [5:0]  rsp_char_code,
   input  logic        rsp_last_char,
   output int          fail_count,
   output int          pending_chars,
   output int          chars_checked
);

   timeunit 1ns;
   timeprecision 1ps;

   import sida_pkg::*;

   localparam int DEC_BASE = 10;

   typedef struct packed {
      char_type code;
      logic     last;
   } text_char_type;

   text_char_type expected_text[$];

   // Split the magnitude into decimal digits and queue the characters, sign first.
   function automatic void predict_text(input logic [31:0] raw);
      logic          neg;
      logic [31:0]   mag;
      logic [3:0]    digit [NUM_DIGITS];
      int            n;
      text_char_type ch;
      neg = raw[BIN_WIDTH-1];
      mag = neg ? (32'd0 - raw) : raw;
      n = 0;
      do begin
         digit[n] = 4'(mag % DEC_BASE);
         mag = mag / DEC_BASE;
         n++;
      end while (mag != 0 && n < NUM_DIGITS);
      if (neg) begin
         ch.code = CODE_MINUS;
         ch.last = 1'b0;
         expected_text.push_back(ch);
      end
      for (int i = n - 1; i >= 0; i--) begin
         ch.code = char_type'(CODE_ZERO + digit[i]);
         ch.last = (i == 0);
         expected_text.push_back(ch);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_text.delete();
         fail_count    = 0;
         chars_checked = 0;
      end else begin
         if (rsp_strobe) begin
            chars_checked++;
            if (expected_text.size() == 0) begin
               $error("unexpected character: char_code %0d last_char %0b",
                      rsp_char_code, rsp_last_char);
               fail_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_char_code !== want.code) begin
                  $error("char_code: expected %0d, got %0d", want.code, rsp_char_code);
                  fail_count++;
               end
               if (rsp_last_char !== want.last) begin
                  $error("last_char: expected %0b, got %0b", want.last, rsp_last_char);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            predict_text(req_value);
      end
      pending_chars = expected_text.size();
   end

endmodule

@@ dv/tb_signed_int_to_decimal_ascii.sv @@
// Testbench top for the signed integer to decimal text converter: stimulus, watchdog, verdict.
module tb_signed_int_to_decimal_ascii;

   timeunit 1ns;
   timeprecision 1ps;

   // Quiet stretch allowed: a full queue ahead of the converter, plus the longest idle gap,
   // taken many times over.
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_VALUES = 87;
   localparam int MAX_GAP      = 50;

   // Values that sit on the edges: zero, single digits, powers of ten and their neighbours,
   // both ends of the range and alternating bit patterns.
   localparam logic [31:0] EDGE_VALUES [20] = '{
      32'd0,          32'd1,          32'd9,          32'd10,
      32'hFFFFFFFF,   32'hFFFFFFF7,   32'hFFFFFFF6,   32'd99,
      32'd100,        32'h7FFFFFFF,   32'h80000000,   32'h80000001,
      32'd1000000000, 32'd999999999,  -32'sd999999999, 32'd1000000009,
      32'h55555555,   32'hAAAAAAAA,   32'd123456789,  -32'sd123456789
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_value;
   logic        rsp_strobe;
   logic [5:0]  rsp_char_code;
   logic        rsp_last_char;

   logic        value_taken;
   int          fail_count;
   int          pending_chars;
   int          chars_checked;
   int          stall_cycles;
   int          values_sent;
   int          negatives_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   sida_text_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .fail_count    (fail_count),
      .pending_chars (pending_chars),
      .chars_checked (chars_checked)
   );

   // Note each accepted transaction so the driver can see it at the following falling edge.
   always @(posedge clock) begin
      value_taken <= !reset && start && !busy;
   end

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d characters outstanding",
                  STALL_LIMIT, pending_chars);
         $display("tb_signed_int_to_decimal_ascii: FAIL");
         $finish;
      end
   end

   // Offer one value and hold it until the block takes it; return on a falling edge.
   task automatic send_value(input logic [31:0] v);
      start     <= 1'b1;
      req_value <= v;
      values_sent++;
      if (v[31])
         negatives_sent++;
      do @(negedge clock); while (!value_taken);
   endtask

   // Drop start for a random stretch, with junk on the value port to prove it is ignored.
   task automatic idle_gap();
      start     <= 1'b0;
      req_value <= $urandom;
      repeat ($urandom_range(MAX_GAP, 1)) @(negedge clock);
   endtask

   // Hold off the sender until every predicted character has come out.
   task automatic hold_until_drained();
      start <= 1'b0;
      do @(negedge clock); while (pending_chars != 0);
   endtask

   // Draw a value: raw bits, a chosen digit count, a power of ten neighbour or a range end.
   function automatic logic [31:0] pick_value();
      longint      lo;
      longint      hi;
      logic [31:0] v;
      case ($urandom_range(3, 0))
         0: begin
            v = $urandom;
         end
         1: begin
            lo = 1;
            repeat ($urandom_range(9, 0)) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483647)
               hi = 64'sd2147483647;
            v = $urandom_range(32'(hi), 32'(lo));
            if ($urandom_range(1, 0))
               v = -v;
         end
         2: begin
            lo = 1;
            repeat ($urandom_range(9, 0)) lo = lo * 10;
            v = 32'(lo) + $urandom_range(2, 0) - 1;
            if ($urandom_range(1, 0))
               v = -v;
         end
         default: begin
            if ($urandom_range(1, 0))
               v = 32'h80000000 + $urandom_range(15, 0);
            else
               v = 32'h7FFFFFFF - $urandom_range(15, 0);
         end
      endcase
      return v;
   endfunction

   initial begin
      int idle_pct [3];
      idle_pct = '{0, 71, 6};
      values_sent    = 0;
      negatives_sent = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_value = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed edge values, back to back so the input queue fills.
      foreach (EDGE_VALUES[i])
         send_value(EDGE_VALUES[i]);

      // Let the block run dry once before the random traffic.
      hold_until_drained();

      // Random traffic in three pacing phases: no gaps, mostly gaps, occasional gaps.
      for (int phase = 0; phase < 3; phase++) begin
         repeat (PHASE_VALUES) begin
            if ($urandom_range(99, 0) < idle_pct[phase])
               idle_gap();
            send_value(pick_value());
         end
      end

      // Wait for the last characters, then allow for anything stray.
      hold_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Converted %0d values (%0d negative, both range ends included), %0d characters",
               values_sent, negatives_sent, chars_checked);
      $display("checked across back-to-back, sparse and lightly gapped input pacing.");
      if (fail_count == 0)
         $display("tb_signed_int_to_decimal_ascii: PASS");
      else
         $display("tb_signed_int_to_decimal_ascii: FAIL");
      $finish;
   end

endmodule
